@@ hw/rtl/swer_pkg.sv @@
// ----------------------------------------------------------------------------
// swer_pkg
// Shared widths, constants and controller/datapath interface types for the
// sliding window exponent recoder.
// ----------------------------------------------------------------------------
package swer_pkg;

  // Default geometry
  localparam int DEF_EXP_WIDTH  = 64;
  localparam int DEF_MAX_WINDOW = 8;

  // Fixed field widths
  localparam int DIGIT_W = 8;   // digit value
  localparam int LEN_W   = 4;   // digit length / window size register
  localparam int OUT_W   = 16;  // output beat payload, byte padded

  // Window size after reset
  localparam logic [LEN_W-1:0] WINDOW_RST = 4'd4;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;   // capture a new exponent
    logic skip;   // drop leading zeros
    logic emit;   // produce one digit into the output register
  } swer_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic in_zero;        // exponent on the input is zero
    logic top_bit;        // current scan bit is a one
    logic out_free;       // output register can take a digit this cycle
    logic last_digit;     // digit formed now ends at bit 0
  } swer_stat_t;

endpackage

@@ hw/rtl/swer_ctrl.sv @@
// ----------------------------------------------------------------------------
// swer_ctrl
// Sequencer: accepts an exponent, runs the leading-zero skip, then steps
// the datapath one digit at a time until the digit ending at bit 0 is out.
// ----------------------------------------------------------------------------
module swer_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  output swer_pkg::swer_cmd_t  cmd,
  input  swer_pkg::swer_stat_t stat
);
  import swer_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SKIP = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (!stat.in_zero) state_next = ST_SKIP;
        end
      end
      ST_SKIP: begin
        if (stat.top_bit) state_next = ST_EMIT;
        else cmd.skip = 1'b1;
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.last_digit) state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

@@ hw/rtl/swer_dp.sv @@
// ----------------------------------------------------------------------------
// swer_dp
// Datapath: window size register, left-aligned scan shifter with remaining
// bit count, window length search and the output digit register.
// ----------------------------------------------------------------------------
module swer_dp #(
  parameter int EXP_WIDTH  = swer_pkg::DEF_EXP_WIDTH,
  parameter int MAX_WINDOW = swer_pkg::DEF_MAX_WINDOW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [swer_pkg::LEN_W-1:0]  cfg_data,
  input  logic [EXP_WIDTH-1:0]        exponent,
  input  swer_pkg::swer_cmd_t         cmd,
  output swer_pkg::swer_stat_t        stat,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [swer_pkg::DIGIT_W-1:0] digit_value,
  output logic [swer_pkg::LEN_W-1:0]  digit_length,
  output logic                        last
);
  import swer_pkg::*;

  localparam int CNT_W = $clog2(EXP_WIDTH + 1);
  localparam logic [LEN_W-1:0] MAXW   = LEN_W'(MAX_WINDOW);
  localparam logic [LEN_W-1:0] K_RST  = (WINDOW_RST > MAXW) ? MAXW : WINDOW_RST;

  logic [LEN_W-1:0]     k_eff;
  logic [EXP_WIDTH-1:0] sreg;
  logic [CNT_W-1:0]     rem;

  logic [LEN_W-1:0]     len;
  logic [DIGIT_W-1:0]   win;
  logic [DIGIT_W-1:0]   value;
  logic                 top_byte_zero;

  // Window size register, clamped on write
  always_ff @(posedge clk) begin
    if (rst) begin
      k_eff <= K_RST;
    end else if (cfg_we) begin
      if (cfg_data == '0) k_eff <= LEN_W'(1);
      else if (cfg_data > MAXW) k_eff <= MAXW;
      else k_eff <= cfg_data;
    end
  end

  // Longest window ending in a one, limited by k and by the bits left
  always_comb begin
    len = LEN_W'(1);
    if (sreg[EXP_WIDTH-1]) begin
      for (int j = 1; j <= MAX_WINDOW; j++) begin
        if ((LEN_W'(j) <= k_eff) && (CNT_W'(j) <= rem) && sreg[EXP_WIDTH-j]) begin
          len = LEN_W'(j);
        end
      end
    end
  end

  assign win           = sreg[EXP_WIDTH-1 -: DIGIT_W];
  assign value         = sreg[EXP_WIDTH-1] ? (win >> (LEN_W'(DIGIT_W) - len)) : '0;
  assign top_byte_zero = (win == '0);

  // Status toward the controller
  assign stat.in_zero    = (exponent == '0);
  assign stat.top_bit    = sreg[EXP_WIDTH-1];
  assign stat.out_free   = !out_valid || out_ready;
  assign stat.last_digit = (rem == CNT_W'(len));

  // Scan shifter and remaining bit count
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sreg <= exponent;
      rem  <= CNT_W'(EXP_WIDTH);
    end else if (cmd.skip) begin
      if (top_byte_zero) begin
        sreg <= sreg << DIGIT_W;
        rem  <= rem - CNT_W'(DIGIT_W);
      end else begin
        sreg <= sreg << 1;
        rem  <= rem - CNT_W'(1);
      end
    end else if (cmd.emit) begin
      sreg <= sreg << len;
      rem  <= rem - CNT_W'(len);
    end
  end

  // Output digit register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      digit_value  <= value;
      digit_length <= len;
      last         <= stat.last_digit;
    end
  end

`ifndef ASSERT_OFF
  // The final digit leaves no bits behind
  a_last_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && stat.last_digit |=> rem == '0)
    else $error("scan count not zero after final digit");

  // A digit is never formed with no bits left
  a_emit_has_bits: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> rem != '0)
    else $error("digit formed past bit 0");

  // Emitted length stays within the window size
  a_len_range: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> digit_length != '0 && digit_length <= k_eff)
    else $error("digit length outside window range");

  // A nonzero window starts with a one at its top bit
  a_window_msb: assert property (@(posedge clk) disable iff (rst)
    cmd.emit && value != '0 |-> (value >> (len - LEN_W'(1))) == DIGIT_W'(1))
    else $error("window value does not start at its top bit");
`endif

endmodule

@@ hw/rtl/sliding_window_exponent_recoder.sv @@
// ----------------------------------------------------------------------------
// sliding_window_exponent_recoder
// Splits one exponent per input beat into sliding-window digits, most
// significant first. Each input beat (s_axis) carries one exponent; each
// output beat (m_axis) carries one digit, tlast on the digit that ends at
// bit 0. A zero exponent produces no output beats. The window size k is set
// through cfg_we/cfg_data (0 reads as 1, values above MAX_WINDOW saturate,
// reset value 4) and may be changed only while the block is idle. After an
// exponent is taken, the scan skips leading zeros a byte at a time (then bit
// by bit), then emits one digit per cycle from the window search on the scan
// shifter while the output register is free to take it. The next exponent
// is accepted as soon as the final digit sits in the output register.
// ----------------------------------------------------------------------------
module sliding_window_exponent_recoder #(
  parameter int EXP_WIDTH  = swer_pkg::DEF_EXP_WIDTH,
  parameter int MAX_WINDOW = swer_pkg::DEF_MAX_WINDOW
) (
  input  logic                              clk,
  input  logic                              rst,
  // Configuration: window size
  input  logic                              cfg_we,
  input  logic [swer_pkg::LEN_W-1:0]        cfg_data,
  // Input stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [((EXP_WIDTH+7)/8)*8-1:0]    s_axis_tdata,   // exponent
  // Output stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [swer_pkg::OUT_W-1:0]        m_axis_tdata,   // digit_value, digit_length
  output logic                              m_axis_tlast    // last
);
  import swer_pkg::*;

  swer_cmd_t          cmd;
  swer_stat_t         stat;
  logic [DIGIT_W-1:0] digit_value;
  logic [LEN_W-1:0]   digit_length;

  swer_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  swer_dp #(
    .EXP_WIDTH  (EXP_WIDTH),
    .MAX_WINDOW (MAX_WINDOW)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .exponent     (s_axis_tdata[EXP_WIDTH-1:0]),
    .cmd          (cmd),
    .stat         (stat),
    .out_ready    (m_axis_tready),
    .out_valid    (m_axis_tvalid),
    .digit_value  (digit_value),
    .digit_length (digit_length),
    .last         (m_axis_tlast)
  );

  // Output beat packing, zero padded to whole bytes
  assign m_axis_tdata = {{(OUT_W - DIGIT_W - LEN_W){1'b0}}, digit_length, digit_value};

endmodule

@@ verif/tb_sliding_window_exponent_recoder.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_exponent_recoder
// Self-checking bench for the sliding window exponent recoder. Exponents are
// streamed in from a queue, each accepted beat is recoded by a local digit
// predictor at the current window size, and every digit beat on the output
// is checked against the oldest predicted digit. Directed corner exponents
// come first, then random phases at several window sizes, with random gaps
// on both stream sides and long output hold-offs to back the block up.
// ----------------------------------------------------------------------------
module tb_sliding_window_exponent_recoder;
  import swer_pkg::*;

  localparam int EXP_W       = DEF_EXP_WIDTH;
  localparam int MAX_K       = DEF_MAX_WINDOW;
  localparam int SETTLE_CYC  = EXP_W + 56;  // drain time after last digit
  localparam int HOLD_CYC    = 500;         // long output hold-off
  localparam int HOLD_EVERY  = 7000;        // digit beats between hold-offs
  localparam int HOLD_COUNT  = 2;
  localparam int STALL_LIMIT = 4000;        // cycles with no beat at all
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 60;

  typedef struct packed {
    logic [DIGIT_W-1:0] value;
    logic [LEN_W-1:0]   length;
    logic               last;
  } digit_t;

  // DUT ports, all driven from time zero
  logic                 clk           = 1'b0;
  logic                 rst           = 1'b1;
  logic                 cfg_we        = 1'b0;
  logic [LEN_W-1:0]     cfg_data      = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [EXP_W-1:0]     s_axis_tdata  = '0;  // exponent
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OUT_W-1:0]     m_axis_tdata;        // digit_value, digit_length
  logic                 m_axis_tlast;        // last

  // Bench state
  logic [EXP_W-1:0] exps_pending[$];
  digit_t           digits_due[$];
  logic [LEN_W-1:0] window_reg   = WINDOW_RST;
  bit               src_idle_en  = 1'b1;
  bit               sink_idle_en = 1'b1;
  int               src_gap      = 0;
  int               sink_stall   = 0;
  int               digit_beats  = 0;
  int               holds_done   = 0;
  int               quiet_cycles = 0;
  int               mismatches   = 0;

  sliding_window_exponent_recoder #(
    .EXP_WIDTH  (EXP_W),
    .MAX_WINDOW (MAX_K)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #4 clk = ~clk;

  // Gap length: mostly none, some short, a few long
  function automatic int draw_gap(input bit enabled);
    int r;
    r = $urandom_range(0, 99);
    if (!enabled || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Recode one exponent into windows, most significant digit first
  task automatic recode_exponent(input logic [EXP_W-1:0] e, input logic [LEN_W-1:0] wsize);
    int     k;
    int     pos;
    int     lim;
    int     len;
    digit_t d;
    logic [EXP_W-1:0] win;
    k = (wsize == 0) ? 1 : (wsize > MAX_K) ? MAX_K : wsize;
    pos = -1;
    for (int i = 0; i < EXP_W; i++) begin
      if (e[i]) pos = i;
    end
    while (pos >= 0) begin
      if (!e[pos]) begin
        len = 1;
        d.value = '0;
      end else begin
        lim = (pos + 1 < k) ? pos + 1 : k;
        len = 1;
        // longest window ending in a one wins
        for (int j = 1; j <= lim; j++) begin
          if (e[pos-j+1]) len = j;
        end
        win = (e >> (pos - len + 1)) & ((64'd1 << len) - 64'd1);
        d.value = win[DIGIT_W-1:0];
      end
      pos -= len;
      d.length = len[LEN_W-1:0];
      d.last = (pos < 0);
      digits_due.push_back(d);
    end
  endtask

  // Random exponent: mixed bit density and top-bit position, a few zeros
  function automatic logic [EXP_W-1:0] rand_exponent();
    int               r;
    int               top;
    logic [EXP_W-1:0] e;
    r = $urandom_range(0, 99);
    if (r < 3) return '0;
    e = {$urandom, $urandom};
    if (r < 20) e = e | {$urandom, $urandom};
    else if (r < 40) e = e & {$urandom, $urandom} & {$urandom, $urandom};
    if (r >= 70) begin
      top = $urandom_range(0, EXP_W - 1);
      if (top < EXP_W - 1) e = e & ((64'd1 << (top + 1)) - 64'd1);
      e[top] = 1'b1;
    end
    return e;
  endfunction

  // Window size write, only while the block is idle
  task automatic set_window(input logic [LEN_W-1:0] v);
    @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v;
    window_reg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait until every exponent is in and every digit is out, then settle
  task automatic drain();
    while (exps_pending.size() > 0 || s_axis_tvalid || digits_due.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  // Input driver: one exponent per beat from the pending queue
  always @(posedge clk) begin
    if (rst) begin
      s_axis_tvalid <= 1'b0;
      src_gap       <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) recode_exponent(s_axis_tdata, window_reg);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (src_gap > 0) begin
          src_gap       <= src_gap - 1;
          s_axis_tvalid <= 1'b0;
        end else if (exps_pending.size() > 0) begin
          s_axis_tdata  <= exps_pending.pop_front();
          s_axis_tvalid <= 1'b1;
          src_gap       <= draw_gap(src_idle_en);
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Output monitor and ready generator
  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
      sink_stall    <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        digit_beats++;
        if (digits_due.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: unexpected digit beat value=%0d len=%0d last=%0b", $realtime,
                     m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tlast);
          mismatches++;
        end else begin
          if (m_axis_tdata[7:0] !== digits_due[0].value ||
              m_axis_tdata[11:8] !== digits_due[0].length ||
              m_axis_tlast !== digits_due[0].last) begin
            if (mismatches < 10)
              $display("%0t: digit mismatch exp value=%0d len=%0d last=%0b, got value=%0d len=%0d last=%0b",
                       $realtime, digits_due[0].value, digits_due[0].length, digits_due[0].last,
                       m_axis_tdata[7:0], m_axis_tdata[11:8], m_axis_tlast);
            mismatches++;
          end
          void'(digits_due.pop_front());
        end
      end
      // long hold-off lets the block back up into its input
      if (holds_done < HOLD_COUNT && digit_beats >= (holds_done + 1) * HOLD_EVERY) begin
        holds_done    <= holds_done + 1;
        sink_stall    <= HOLD_CYC;
        m_axis_tready <= 1'b0;
      end else if (sink_stall > 0) begin
        sink_stall    <= sink_stall - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
        sink_stall    <= draw_gap(sink_idle_en);
      end
    end
  end

  // Watchdog on cycles with no beat on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("sliding_window_exponent_recoder regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Stimulus sequence
  initial begin
    logic [LEN_W-1:0] k_plan[RAND_PHASES];
    k_plan = '{4'd0, 4'd15, 4'd1, 4'd8, 4'd2, 4'd9, 4'd3, 4'd6};
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset window size, extremes and cut at bit 0
    exps_pending.push_back(64'h0);
    exps_pending.push_back(64'h1);
    exps_pending.push_back(64'h2);
    exps_pending.push_back(64'h3);
    exps_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    exps_pending.push_back(64'h8000_0000_0000_0000);
    exps_pending.push_back(64'h8000_0000_0000_0001);
    exps_pending.push_back(64'h5555_5555_5555_5555);
    exps_pending.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    exps_pending.push_back(64'h5);
    exps_pending.push_back(64'hB7);
    exps_pending.push_back(64'hF0F0_0F0F_1234_5678);
    drain();

    // Zero window size reads as one
    set_window(4'd0);
    exps_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    exps_pending.push_back(64'hA5);
    exps_pending.push_back(64'h8000_0000_0000_0001);
    drain();

    // Oversized window saturates
    set_window(4'd15);
    exps_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    exps_pending.push_back(64'h1FF);
    exps_pending.push_back(64'h8000_0000_0000_0101);
    exps_pending.push_back(64'hDEAD_BEEF_0123_4567);
    drain();

    set_window(4'd8);
    exps_pending.push_back(64'hFF);
    exps_pending.push_back(64'h181);
    exps_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    set_window(4'd1);
    exps_pending.push_back(64'hFFFF_FFFF_FFFF_FFFF);
    exps_pending.push_back(64'h8000_0000_0000_0000);
    drain();

    // Random phases, each at its own window size and idle profile
    for (int p = 0; p < RAND_PHASES; p++) begin
      set_window((p == RAND_PHASES - 1) ? LEN_W'($urandom_range(0, 15)) : k_plan[p]);
      src_idle_en  = ($urandom_range(0, 3) != 0);
      sink_idle_en = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < PHASE_ITEMS; n++) exps_pending.push_back(rand_exponent());
      drain();
    end

    if (mismatches == 0 && digits_due.size() == 0) begin
      $display("sliding_window_exponent_recoder regression: pass");
    end else begin
      $display("sliding_window_exponent_recoder regression: fail");
    end
    $finish;
  end

endmodule
